FILE: hw/rtl/btb_pkg.sv
package btb_pkg;

   localparam int BTB_ENTRIES = 32;
   localparam int MAX_HISTORY = 8;
   localparam int LINE_W      = $clog2(BTB_ENTRIES);
   localparam int HIST_W      = MAX_HISTORY;
   localparam int SLOTS       = 1 << MAX_HISTORY;
   localparam int TAG_W       = 32 - 2 - LINE_W;
   localparam int LADDR_W     = LINE_W + HIST_W;
   localparam int MAX_TAG     = 30;

   localparam logic [2:0] CSR_HISTORY_BITS  = 3'd0;
   localparam logic [2:0] CSR_TAG_BITS      = 3'd1;
   localparam logic [2:0] CSR_INITIAL_STATE = 3'd2;
   localparam logic [2:0] CSR_GLOBAL_HIST   = 3'd3;
   localparam logic [2:0] CSR_GLOBAL_TABLE  = 3'd4;
   localparam logic [2:0] CSR_SHARE_MODE    = 3'd5;

   localparam logic [1:0] SHARE_NONE = 2'd0;
   localparam logic [1:0] SHARE_LOW  = 2'd1;
   localparam logic [1:0] SHARE_HIGH = 2'd2;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENTRY,
      ST_FILL,
      ST_ISSUE,
      ST_COUNT
   } state_type;

   typedef struct packed {
      logic              we;
      logic [LINE_W-1:0] idx;
      logic [TAG_W-1:0]  tag;
      logic [31:0]       target;
      logic [HIST_W-1:0] hist;
   } entry_wr_type;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [31:0]       target;
      logic [HIST_W-1:0] hist;
   } entry_rd_type;

   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic               shared;
      logic [LADDR_W-1:0] local_addr;
      logic [HIST_W-1:0]  slot;
      logic [1:0]         wdata;
   } ctr_req_type;

   function automatic logic [HIST_W-1:0] hist_mask(input logic [3:0] n);
      logic [HIST_W-1:0] m;
      for (int i = 0; i < HIST_W; i++) begin
         m[i] = (i < int'(n)) || (i == 0);
      end
      return m;
   endfunction

   function automatic logic [TAG_W-1:0] tag_mask(input logic [4:0] n);
      logic [TAG_W-1:0] m;
      for (int i = 0; i < TAG_W; i++) begin
         m[i] = (i < int'(n)) || (i == 0);
      end
      return m;
   endfunction

endpackage

FILE: hw/rtl/btb_entry_store.sv
module btb_entry_store
   import btb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [LINE_W-1:0] rd_idx,
   input  entry_wr_type      wr,
   output entry_rd_type      rd
);

   logic [TAG_W-1:0]       tag_mem    [BTB_ENTRIES];
   logic [31:0]            target_mem [BTB_ENTRIES];
   logic [HIST_W-1:0]      hist_mem   [BTB_ENTRIES];
   logic [BTB_ENTRIES-1:0] valid_ff;
   logic [BTB_ENTRIES-1:0] valid_in;
   logic                   rd_valid_ff;
   logic [TAG_W-1:0]       rd_tag_ff;
   logic [31:0]            rd_target_ff;
   logic [HIST_W-1:0]      rd_hist_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.we) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         tag_mem[wr.idx]    <= wr.tag;
         target_mem[wr.idx] <= wr.target;
         hist_mem[wr.idx]   <= wr.hist;
      end
      if (rd_en) begin
         rd_valid_ff  <= valid_ff[rd_idx];
         rd_tag_ff    <= tag_mem[rd_idx];
         rd_target_ff <= target_mem[rd_idx];
         rd_hist_ff   <= hist_mem[rd_idx];
      end
   end

   assign rd = '{valid: rd_valid_ff, tag: rd_tag_ff, target: rd_target_ff, hist: rd_hist_ff};

endmodule

FILE: hw/rtl/btb_counter_store.sv
module btb_counter_store
   import btb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        shared_clear,
   input  logic [1:0]  initial_state,
   input  ctr_req_type req,
   output logic [1:0]  rdata
);

   logic [1:0]       local_mem  [BTB_ENTRIES*SLOTS];
   logic [1:0]       shared_mem [SLOTS];
   logic [SLOTS-1:0] svalid_ff;
   logic [SLOTS-1:0] svalid_in;
   logic [1:0]       local_rd_ff;
   logic [1:0]       shared_rd_ff;
   logic             shared_ok_ff;
   logic             sel_shared_ff;

   always_comb begin
      svalid_in = svalid_ff;
      if (shared_clear) begin
         svalid_in = '0;
      end else if (req.wr_en && req.shared) begin
         svalid_in[req.slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         svalid_ff <= '0;
      end else begin
         svalid_ff <= svalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en && !req.shared) begin
         local_mem[req.local_addr] <= req.wdata;
      end
      if (req.wr_en && req.shared) begin
         shared_mem[req.slot] <= req.wdata;
      end
      if (req.rd_en) begin
         local_rd_ff   <= local_mem[req.local_addr];
         shared_rd_ff  <= shared_mem[req.slot];
         shared_ok_ff  <= svalid_ff[req.slot];
         sel_shared_ff <= req.shared;
      end
   end

   // an unwritten shared slot reads as the initial state
   assign rdata = !sel_shared_ff ? local_rd_ff :
                  (shared_ok_ff ? shared_rd_ff : initial_state);

endmodule

FILE: hw/rtl/btb_two_level_branch_predictor.sv
// two-level branch predictor with a direct mapped target buffer. a request is
// taken when start is high and busy is low; its single response shows on the
// rsp_ ports for one cycle with rsp_valid and cannot be held off. a predict or
// an update that hits passes through entry read, counter read and result
// register before its response; a predict that misses answers straight from
// the entry read. an update that allocates a line also refills that line's
// 256 local counters, one per cycle through the single counter memory port,
// before its counter read. busy drops in the response cycle, so the next request
// can be taken at the edge that takes the response. the shared counter table
// needs no clearing pass: a valid bit per slot makes an unwritten slot read as
// the initial state, and writing initial_state clears those bits. csr writes
// are always ready and are meant for idle time.
module btb_two_level_branch_predictor
   import btb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_target_pc,
   input  logic        req_taken,
   input  logic [31:0] req_predicted_dst,
   output logic        rsp_valid,
   output logic        rsp_predict_taken,
   output logic [31:0] rsp_predicted_target,
   output logic        rsp_flushed,
   output logic [31:0] rsp_branch_count,
   output logic [31:0] rsp_flush_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   state_type state_ff, state_in;

   // control registers
   logic [3:0] hist_bits_ff;
   logic [4:0] tag_bits_ff;
   logic [1:0] init_state_ff;
   logic       ghist_mode_ff;
   logic       gtable_mode_ff;
   logic [1:0] share_mode_ff;
   logic       csr_we;

   // request context
   logic              op_ff;
   logic [31:0]       pc_ff;
   logic [31:0]       tgt_ff;
   logic              tk_ff;
   logic [31:0]       pdst_ff;
   logic [HIST_W-1:0] hbase_ff, hbase_in;
   logic [31:0]       etarget_ff;
   logic [HIST_W-1:0] slot_ff, slot_in;
   logic [HIST_W-1:0] fill_ff;

   // global state
   logic [HIST_W-1:0] ghist_ff;
   logic [31:0]       branch_ff;
   logic [31:0]       flush_ff;

   // response registers
   logic        rsp_valid_ff;
   logic        rsp_taken_ff;
   logic [31:0] rsp_target_ff;
   logic        rsp_flushed_ff;

   entry_wr_type ent_wr;
   entry_rd_type ent_rd;
   ctr_req_type  ctr_req;
   logic [1:0]   ctr_rdata;

   logic [LINE_W-1:0] line;
   logic [TAG_W-1:0]  tag_cur;
   logic              hit;
   logic [HIST_W-1:0] hmask;
   logic [HIST_W-1:0] hist_use;
   logic [HIST_W-1:0] hist_next;
   logic [1:0]        ctr_next;
   logic [31:0]       pc_plus4;
   logic [31:0]       actual;
   logic              mispredict;
   logic              accept;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign csr_we   = csr_valid && csr_ready;

   assign line     = pc_ff[2 +: LINE_W];
   assign tag_cur  = pc_ff[31 -: TAG_W] & tag_mask(tag_bits_ff);
   assign hit      = ent_rd.valid && (ent_rd.tag == tag_cur);
   assign hmask    = hist_mask(hist_bits_ff);
   assign pc_plus4 = pc_ff + 32'd4;
   assign actual   = tk_ff ? tgt_ff : pc_plus4;
   assign mispredict = (pdst_ff != actual);

   // history feeding the counter index
   assign hist_use = ghist_mode_ff ? ghist_ff : hbase_ff;

   always_comb begin
      slot_in = hist_use & hmask;
      case (share_mode_ff)
         SHARE_LOW:  slot_in = slot_in ^ (pc_ff[2 +: HIST_W] & hmask);
         SHARE_HIGH: slot_in = slot_in ^ (pc_ff[16 +: HIST_W] & hmask);
         default:    slot_in = slot_in;
      endcase
   end

   // history shifted with the resolved direction
   assign hist_next = {hist_use[HIST_W-2:0], tk_ff} & hmask;

   always_comb begin
      ctr_next = ctr_rdata;
      if (tk_ff) begin
         if (ctr_rdata != 2'd3) ctr_next = ctr_rdata + 2'd1;
      end else begin
         if (ctr_rdata != 2'd0) ctr_next = ctr_rdata - 2'd1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_ENTRY;
         end
         ST_ENTRY: begin
            if (hit) state_in = ST_ISSUE;
            else if (op_ff == OP_UPDATE) state_in = ST_FILL;
            else state_in = ST_IDLE;
         end
         ST_FILL: begin
            if (fill_ff == '1) state_in = ST_ISSUE;
         end
         ST_ISSUE: state_in = ST_COUNT;
         ST_COUNT: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      ctr_req = '{rd_en: 1'b0, wr_en: 1'b0, shared: gtable_mode_ff,
                  local_addr: {line, slot_ff}, slot: slot_ff, wdata: ctr_next};
      ent_wr  = '{we: 1'b0, idx: line, tag: tag_cur, target: tgt_ff,
                  hist: ghist_mode_ff ? hbase_ff : hist_next};
      hbase_in = hbase_ff;
      unique case (state_ff)
         ST_ENTRY: begin
            // an allocated line starts with a clear history
            hbase_in = hit ? ent_rd.hist : '0;
         end
         ST_FILL: begin
            ctr_req.wr_en      = 1'b1;
            ctr_req.shared     = 1'b0;
            ctr_req.local_addr = {line, fill_ff};
            ctr_req.wdata      = init_state_ff;
         end
         ST_ISSUE: begin
            ctr_req.rd_en      = 1'b1;
            ctr_req.local_addr = {line, slot_in};
            ctr_req.slot       = slot_in;
         end
         ST_COUNT: begin
            ctr_req.wr_en = (op_ff == OP_UPDATE);
            ent_wr.we     = (op_ff == OP_UPDATE);
         end
         default: begin
         end
      endcase
   end

   btb_entry_store u_entry (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_idx (req_pc[2 +: LINE_W]),
      .wr     (ent_wr),
      .rd     (ent_rd)
   );

   btb_counter_store u_counter (
      .clock         (clock),
      .reset         (reset),
      .shared_clear  (csr_we && (csr_index == CSR_INITIAL_STATE)),
      .initial_state (init_state_ff),
      .req           (ctr_req),
      .rdata         (ctr_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         hist_bits_ff   <= 4'd2;
         tag_bits_ff    <= 5'd8;
         init_state_ff  <= 2'd1;
         ghist_mode_ff  <= 1'b0;
         gtable_mode_ff <= 1'b0;
         share_mode_ff  <= SHARE_NONE;
         ghist_ff       <= '0;
         branch_ff      <= '0;
         flush_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         fill_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HISTORY_BITS:  hist_bits_ff   <= csr_wdata[3:0];
               CSR_TAG_BITS:      tag_bits_ff    <= csr_wdata;
               CSR_INITIAL_STATE: init_state_ff  <= csr_wdata[1:0];
               CSR_GLOBAL_HIST:   ghist_mode_ff  <= csr_wdata[0];
               CSR_GLOBAL_TABLE:  gtable_mode_ff <= csr_wdata[0];
               CSR_SHARE_MODE:    share_mode_ff  <= csr_wdata[1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_FILL) begin
            fill_ff <= fill_ff + 1'b1;
         end else begin
            fill_ff <= '0;
         end
         if ((state_ff == ST_ENTRY) && !hit && (op_ff == OP_PREDICT)) begin
            rsp_valid_ff <= 1'b1;
         end
         if (state_ff == ST_COUNT) begin
            rsp_valid_ff <= 1'b1;
            if (op_ff == OP_UPDATE) begin
               branch_ff <= branch_ff + 32'd1;
               if (mispredict) flush_ff <= flush_ff + 32'd1;
               if (ghist_mode_ff) ghist_ff <= hist_next;
            end
         end
      end
   end

   // request context and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         pc_ff   <= req_pc;
         tgt_ff  <= req_target_pc;
         tk_ff   <= req_taken;
         pdst_ff <= req_predicted_dst;
      end
      hbase_ff <= hbase_in;
      if (state_ff == ST_ENTRY) begin
         etarget_ff <= ent_rd.target;
      end
      if (state_ff == ST_ISSUE) begin
         slot_ff <= slot_in;
      end
      if ((state_ff == ST_ENTRY) && !hit && (op_ff == OP_PREDICT)) begin
         rsp_taken_ff   <= 1'b0;
         rsp_target_ff  <= pc_plus4;
         rsp_flushed_ff <= 1'b0;
      end
      if (state_ff == ST_COUNT) begin
         if (op_ff == OP_UPDATE) begin
            rsp_taken_ff   <= 1'b0;
            rsp_target_ff  <= '0;
            rsp_flushed_ff <= mispredict;
         end else begin
            rsp_taken_ff   <= ctr_rdata[1];
            rsp_target_ff  <= ctr_rdata[1] ? etarget_ff : pc_plus4;
            rsp_flushed_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predict_taken    = rsp_taken_ff;
   assign rsp_predicted_target = rsp_target_ff;
   assign rsp_flushed          = rsp_flushed_ff;
   assign rsp_branch_count     = branch_ff;
   assign rsp_flush_count      = flush_ff;

endmodule

FILE: hw/rtl/btb_checker.sv
module btb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_predict_taken,
   input logic        rsp_flushed,
   input logic [31:0] rsp_branch_count
);

   // sync reset leaves the block idle and silent
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response longer than one cycle");

   a_update_no_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flushed |-> !rsp_predict_taken)
      else $error("flushed response marked taken");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(reset) |-> $stable(rsp_branch_count))
      else $error("branch count moved without a response");

endmodule

bind btb_two_level_branch_predictor btb_checker u_btb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_predict_taken(rsp_predict_taken),
   .rsp_flushed      (rsp_flushed),
   .rsp_branch_count (rsp_branch_count)
);

FILE: bench/btb_two_level_branch_predictor_checker.sv
module btb_two_level_branch_predictor_checker
   import btb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_target_pc,
   input  logic        req_taken,
   input  logic [31:0] req_predicted_dst,
   input  logic        rsp_valid,
   input  logic        rsp_predict_taken,
   input  logic [31:0] rsp_predicted_target,
   input  logic        rsp_flushed,
   input  logic [31:0] rsp_branch_count,
   input  logic [31:0] rsp_flush_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [4:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        ptaken;
      logic [31:0] ptarget;
      logic        flushed;
      logic [31:0] branches;
      logic [31:0] flushes;
   } outcome_type;

   outcome_type outcome_q[$];

   logic [3:0]  hist_len;
   logic [4:0]  tag_len;
   logic [1:0]  init_ctr;
   logic        ghist_mode;
   logic        gtable_mode;
   logic [1:0]  share_sel;
   logic        line_valid[BTB_ENTRIES];
   logic [29:0] line_tag[BTB_ENTRIES];
   logic [31:0] line_target[BTB_ENTRIES];
   logic [7:0]  line_hist[BTB_ENTRIES];
   logic [1:0]  local_ctr[BTB_ENTRIES][SLOTS];
   logic [1:0]  shared_ctr[SLOTS];
   logic [7:0]  ghist;
   logic [31:0] branch_total;
   logic [31:0] flush_total;

   function automatic logic [7:0] hmask();
      int n;
      n = hist_len;
      if (n < 1) n = 1;
      if (n > MAX_HISTORY) n = MAX_HISTORY;
      return 8'((1 << n) - 1);
   endfunction

   function automatic logic [29:0] tag_from(logic [31:0] pc);
      int n;
      n = tag_len;
      if (n < 1) n = 1;
      if (n > 30) n = 30;
      return 30'((pc >> 7) & ((64'd1 << n) - 1));
   endfunction

   function automatic logic [7:0] slot_from(logic [31:0] pc, logic [7:0] h);
      logic [7:0] s;
      s = h & hmask();
      if (share_sel == SHARE_LOW) s ^= pc[9:2] & hmask();
      else if (share_sel == SHARE_HIGH) s ^= pc[23:16] & hmask();
      return s;
   endfunction

   // apply one request to the model state and queue its response
   task automatic predict_branch(logic op, logic [31:0] pc, logic [31:0] tgt,
                                 logic tk, logic [31:0] pdst);
      int ln;
      logic [29:0] tg;
      logic [7:0] sl;
      logic [1:0] c;
      logic [31:0] actual;
      outcome_type o;
      ln = pc[6:2];
      tg = tag_from(pc);
      o = '0;
      if (op == OP_PREDICT) begin
         o.ptarget = pc + 4;
         if (line_valid[ln] && line_tag[ln] == tg) begin
            sl = slot_from(pc, ghist_mode ? ghist : line_hist[ln]);
            c = gtable_mode ? shared_ctr[sl] : local_ctr[ln][sl];
            if (c >= 2) begin
               o.ptaken = 1;
               o.ptarget = line_target[ln];
            end
         end
      end else begin
         actual = tk ? tgt : pc + 4;
         branch_total++;
         if (pdst != actual) begin
            flush_total++;
            o.flushed = 1;
         end
         if (!line_valid[ln] || line_tag[ln] != tg) begin
            line_valid[ln] = 1;
            line_tag[ln] = tg;
            line_hist[ln] = 0;
            for (int i = 0; i < SLOTS; i++) local_ctr[ln][i] = init_ctr;
         end
         line_target[ln] = tgt;
         sl = slot_from(pc, ghist_mode ? ghist : line_hist[ln]);
         c = gtable_mode ? shared_ctr[sl] : local_ctr[ln][sl];
         if (tk && c < 3) c++;
         else if (!tk && c > 0) c--;
         if (gtable_mode) shared_ctr[sl] = c;
         else local_ctr[ln][sl] = c;
         if (ghist_mode) ghist = ((ghist << 1) | tk) & hmask();
         else line_hist[ln] = ((line_hist[ln] << 1) | tk) & hmask();
      end
      o.branches = branch_total;
      o.flushes = flush_total;
      outcome_q.push_back(o);
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         hist_len = 2; tag_len = 8; init_ctr = 1;
         ghist_mode = 0; gtable_mode = 0; share_sel = SHARE_NONE;
         for (int i = 0; i < BTB_ENTRIES; i++) begin
            line_valid[i] = 0; line_hist[i] = 0;
         end
         for (int i = 0; i < SLOTS; i++) shared_ctr[i] = 1;
         ghist = 0; branch_total = 0; flush_total = 0;
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected response", $time);
               fail_count++;
            end else begin
               e = outcome_q.pop_front();
               if (e.ptaken !== rsp_predict_taken) begin
                  $display("%0t: predict_taken exp %0h got %0h", $time, e.ptaken,
                           rsp_predict_taken);
                  fail_count++;
               end
               if (e.ptarget !== rsp_predicted_target) begin
                  $display("%0t: predicted_target exp %h got %h", $time, e.ptarget,
                           rsp_predicted_target);
                  fail_count++;
               end
               if (e.flushed !== rsp_flushed) begin
                  $display("%0t: flushed exp %0h got %0h", $time, e.flushed,
                           rsp_flushed);
                  fail_count++;
               end
               if (e.branches !== rsp_branch_count) begin
                  $display("%0t: branch_count exp %0d got %0d", $time, e.branches,
                           rsp_branch_count);
                  fail_count++;
               end
               if (e.flushes !== rsp_flush_count) begin
                  $display("%0t: flush_count exp %0d got %0d", $time, e.flushes,
                           rsp_flush_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            predict_branch(req_operation, req_pc, req_target_pc, req_taken,
                           req_predicted_dst);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HISTORY_BITS:  hist_len = csr_wdata[3:0];
               CSR_TAG_BITS:      tag_len = csr_wdata;
               CSR_INITIAL_STATE: begin
                  init_ctr = csr_wdata[1:0];
                  for (int i = 0; i < SLOTS; i++) shared_ctr[i] = init_ctr;
               end
               CSR_GLOBAL_HIST:   ghist_mode = csr_wdata[0];
               CSR_GLOBAL_TABLE:  gtable_mode = csr_wdata[0];
               CSR_SHARE_MODE:    share_sel = csr_wdata[1:0];
               default: ;
            endcase
         end
      end
      pending = outcome_q.size();
   end
endmodule

FILE: bench/btb_two_level_branch_predictor_tb.sv
module btb_two_level_branch_predictor_tb
   import btb_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_operation = OP_PREDICT;
   logic [31:0] req_pc = 0;
   logic [31:0] req_target_pc = 0;
   logic        req_taken = 0;
   logic [31:0] req_predicted_dst = 0;
   logic        rsp_valid;
   logic        rsp_predict_taken;
   logic [31:0] rsp_predicted_target;
   logic        rsp_flushed;
   logic [31:0] rsp_branch_count;
   logic [31:0] rsp_flush_count;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_HISTORY_BITS;
   logic [4:0]  csr_wdata = 0;
   int          fail_count;
   int          pending;

   // a small pool of branch addresses so lines hit, alias and get replaced
   logic [31:0] hot_pc[16];

   always #5 clock = ~clock;

   btb_two_level_branch_predictor uut (.*);

   btb_two_level_branch_predictor_checker checker_i (.*);

   // random idle cycles, mostly short, now and then long
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      repeat (n) @(posedge clock);
   endtask

   // drive one request and hold it until the block takes it
   task automatic send_request(logic op, logic [31:0] pc, logic [31:0] tgt,
                               logic tk, logic [31:0] pdst, bit gaps);
      start <= 1;
      req_operation <= op;
      req_pc <= pc;
      req_target_pc <= tgt;
      req_taken <= tk;
      req_predicted_dst <= pdst;
      do @(posedge clock); while (busy);
      start <= 0;
      // the block is busy for at least this cycle anyway
      @(posedge clock);
      if (gaps) idle_gap();
   endtask

   task automatic write_csr(logic [2:0] idx, logic [4:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // wait until all responses are in and the block is idle, then a margin more
   task automatic drain();
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // one random request, predicts and updates mostly on hot pcs
   task automatic random_request();
      logic [31:0] pc, tgt, pdst;
      logic tk;
      pc = ($urandom_range(0, 9) < 8) ? hot_pc[$urandom_range(0, 15)] : $urandom();
      tgt = ($urandom_range(0, 3) == 0) ? $urandom() : pc + 32'($urandom_range(8, 4096));
      tk = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
         0: pdst = tk ? tgt : pc + 4;
         1: pdst = tk ? pc + 4 : tgt;
         2: pdst = $urandom();
         default: pdst = tgt;
      endcase
      send_request(logic'($urandom_range(0, 1)), pc, tgt, tk, pdst, 1);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 16; i++)
         hot_pc[i] = ($urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_0000) |
                     {$urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 63))
                      << 2} | (i < 4 ? 32'(i) : 32'd0);

      // directed: extremes, predict and update, miss then hit, flush cases
      send_request(OP_PREDICT, 32'h0, 32'h0, 0, 32'h0, 0);
      send_request(OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
      send_request(OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 1, 32'h4, 0);
      send_request(OP_PREDICT, 32'h0, 32'h0, 0, 32'h0, 0);
      send_request(OP_UPDATE, 32'hFFFF_FFFF, 32'h0, 0, 32'h3, 0);
      send_request(OP_UPDATE, 32'hFFFF_FFFF, 32'h1234, 0, 32'h0, 0);
      send_request(OP_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
      // same line, different tag: replacement
      send_request(OP_UPDATE, 32'h0000_1000, 32'hAAAA_5554, 1, 32'hAAAA_5554, 0);
      send_request(OP_UPDATE, 32'h0000_1000, 32'h5555_AAA8, 1, 32'h0, 0);
      send_request(OP_PREDICT, 32'h0000_1000, 32'h0, 0, 32'h0, 0);
      send_request(OP_PREDICT, 32'h0000_0000, 32'h0, 0, 32'h0, 0);
      // wait for all responses before any csr write
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_HISTORY_BITS, 5'd0); write_csr(CSR_TAG_BITS, 5'd0);
               write_csr(CSR_INITIAL_STATE, 5'd3); write_csr(CSR_SHARE_MODE, 5'd3);
            end
            1: begin
               write_csr(CSR_HISTORY_BITS, 5'd8); write_csr(CSR_TAG_BITS, 5'd30);
               write_csr(CSR_GLOBAL_HIST, 5'd1); write_csr(CSR_GLOBAL_TABLE, 5'd1);
               write_csr(CSR_SHARE_MODE, 5'(SHARE_LOW));
               write_csr(CSR_INITIAL_STATE, 5'd0);
            end
            2: begin
               write_csr(CSR_HISTORY_BITS, 5'd15); write_csr(CSR_TAG_BITS, 5'd31);
               write_csr(CSR_SHARE_MODE, 5'(SHARE_HIGH));
               write_csr(CSR_INITIAL_STATE, 5'd2);
            end
            3: begin
               write_csr(CSR_GLOBAL_HIST, 5'd0); write_csr(CSR_GLOBAL_TABLE, 5'd0);
               write_csr(CSR_HISTORY_BITS, 5'd1); write_csr(CSR_TAG_BITS, 5'd1);
            end
            default: begin
               // random setting, upper wdata bits included
               write_csr(CSR_HISTORY_BITS, 5'($urandom()));
               write_csr(CSR_TAG_BITS, 5'($urandom()));
               write_csr(CSR_INITIAL_STATE, 5'($urandom()));
               write_csr(CSR_GLOBAL_HIST, 5'($urandom()));
               write_csr(CSR_GLOBAL_TABLE, 5'($urandom()));
               write_csr(CSR_SHARE_MODE, 5'($urandom()));
            end
         endcase
         for (int k = 0; k < 153; k++) begin
            random_request();
            // hold off until everything is answered
            if (k == 70) while (pending != 0) @(posedge clock);
         end
         drain();
      end

      if (fail_count == 0)
         $display("btb_two_level_branch_predictor verification clean");
      else
         $display("btb_two_level_branch_predictor verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("btb_two_level_branch_predictor verification failed");
      $finish;
   end
endmodule

FILE: sim.f
hw/rtl/btb_pkg.sv
hw/rtl/btb_entry_store.sv
hw/rtl/btb_counter_store.sv
hw/rtl/btb_two_level_branch_predictor.sv
hw/rtl/btb_checker.sv
bench/btb_two_level_branch_predictor_checker.sv
bench/btb_two_level_branch_predictor_tb.sv
